### src/adsr_envelope_generator_top_macros.svh
// Assertion macros for the checker file adsr_chk.sv.
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ADSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/adsr_pkg.sv
package adsr_pkg;

	localparam int GateW  = 12;
	localparam int TimeW  = 12;
	localparam int LevelW = 12;
	localparam int PhaseW = 3;
	localparam int TimerW = 16;
	localparam int SpanW  = 10;
	localparam int QuoW   = 10;
	localparam int DivCntW = 4;

	localparam logic [GateW-1:0]  GATE_THRESHOLD = 12'd2528;
	localparam logic [LevelW-1:0] LEVEL_ZERO     = 12'd2048;
	localparam logic [LevelW-1:0] LEVEL_PEAK     = 12'd3008;
	localparam logic [LevelW-1:0] LEVEL_SUSTAIN  = 12'd2528;
	localparam logic [SpanW-1:0]  ATTACK_SPAN    = 10'd960;
	localparam logic [SpanW-1:0]  FALL_SPAN      = 10'd480;
	localparam int                SUSTAIN_HOLD   = 4;

	localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
	localparam logic [PhaseW-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PhaseW-1:0] PH_DECAY   = 3'd2;
	localparam logic [PhaseW-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PhaseW-1:0] PH_RELEASE = 3'd4;

	localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(QuoW - 1);

	typedef enum logic [6:0] {
		OP_WAIT = 7'b0000001,
		OP_DEB  = 7'b0000010,
		OP_EVAL = 7'b0000100,
		OP_CHK  = 7'b0001000,
		OP_MUL  = 7'b0010000,
		OP_DIV  = 7'b0100000,
		OP_OUT  = 7'b1000000
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS = 3'd0,
		C_IN     = 3'd1,
		C_HOLD   = 3'd2,
		C_DIV    = 3'd3,
		C_DLAST  = 3'd4,
		C_OFREE  = 3'd5
	} csel_t;

	typedef logic [2:0] step_t;

	localparam step_t ST_WAIT = 3'd0;
	localparam step_t ST_DEB  = 3'd1;
	localparam step_t ST_EVAL = 3'd2;
	localparam step_t ST_CHK  = 3'd3;
	localparam step_t ST_MUL  = 3'd4;
	localparam step_t ST_DIV  = 3'd5;
	localparam step_t ST_OUT  = 3'd6;

	typedef struct packed {
		op_t   op;
		csel_t csel;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic hold;
		logic need_div;
		logic div_last;
		logic out_free;
	} seq_cond_t;

	function automatic ucode_t ucode_rom(input step_t addr);
		ucode_t cw;
		case (addr)
			ST_WAIT: cw = '{op: OP_WAIT, csel: C_IN,     tgt_t: ST_DEB,  tgt_f: ST_WAIT};
			ST_DEB:  cw = '{op: OP_DEB,  csel: C_ALWAYS, tgt_t: ST_EVAL, tgt_f: ST_EVAL};
			ST_EVAL: cw = '{op: OP_EVAL, csel: C_HOLD,   tgt_t: ST_CHK,  tgt_f: ST_EVAL};
			ST_CHK:  cw = '{op: OP_CHK,  csel: C_DIV,    tgt_t: ST_MUL,  tgt_f: ST_OUT};
			ST_MUL:  cw = '{op: OP_MUL,  csel: C_ALWAYS, tgt_t: ST_DIV,  tgt_f: ST_DIV};
			ST_DIV:  cw = '{op: OP_DIV,  csel: C_DLAST,  tgt_t: ST_OUT,  tgt_f: ST_DIV};
			ST_OUT:  cw = '{op: OP_OUT,  csel: C_OFREE,  tgt_t: ST_WAIT, tgt_f: ST_OUT};
			default: cw = '{op: OP_WAIT, csel: C_ALWAYS, tgt_t: ST_WAIT, tgt_f: ST_WAIT};
		endcase
		return cw;
	endfunction

endpackage

### src/adsr_useq.sv
module adsr_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adsr_pkg::seq_cond_t  cond,
	output adsr_pkg::op_t        op
);

	adsr_pkg::step_t  step_q;
	adsr_pkg::ucode_t cw;
	logic             taken;

	always_comb begin
		cw = adsr_pkg::ucode_rom(step_q);
		case (cw.csel)
			adsr_pkg::C_ALWAYS: taken = 1'b1;
			adsr_pkg::C_IN:     taken = cond.in_valid;
			adsr_pkg::C_HOLD:   taken = cond.hold;
			adsr_pkg::C_DIV:    taken = cond.need_div;
			adsr_pkg::C_DLAST:  taken = cond.div_last;
			adsr_pkg::C_OFREE:  taken = cond.out_free;
			default:            taken = 1'b1;
		endcase
	end

	assign op = cw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= adsr_pkg::ST_WAIT;
		end else begin
			step_q <= taken ? cw.tgt_t : cw.tgt_f;
		end
	end

endmodule

### src/adsr_envelope_generator_top.sv
// Linear ADSR envelope generator. Each input item carries one gate sample and the
// attack, decay and release lengths; each produces exactly one result item with the
// envelope level, the phase and the retrigger toggle. A small microcoded sequencer
// runs every item: an accept step, a gate debouncer step, an evaluation step that
// repeats for each phase change, a branch step and an output step. While attack,
// decay or release is still ramping, a multiply step and a restoring divider are
// added. A new item is accepted only when the previous one has been handed to the
// output register; a result waiting there does not block the next item until that
// item's own result is ready. skip_sustain lives at byte address 0 of the register
// port; the user must write it only while the block is idle, which the block itself
// does not enforce.
module adsr_envelope_generator_top #(
	parameter int DEBOUNCE_LIMIT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [adsr_pkg::GateW-1:0]     gate_sample,
	input  logic [adsr_pkg::TimeW-1:0]     attack_time,
	input  logic [adsr_pkg::TimeW-1:0]     decay_time,
	input  logic [adsr_pkg::TimeW-1:0]     release_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [adsr_pkg::LevelW-1:0]    level,
	output logic [adsr_pkg::PhaseW-1:0]    phase,
	output logic                           trigger_toggle
);

	localparam int HoldMax = (DEBOUNCE_LIMIT > adsr_pkg::SUSTAIN_HOLD) ?
		DEBOUNCE_LIMIT : adsr_pkg::SUSTAIN_HOLD;
	localparam int CntW = $clog2(HoldMax + 1) + 1;
	localparam logic signed [CntW-1:0] LimPos  = CntW'(DEBOUNCE_LIMIT);
	localparam logic signed [CntW-1:0] LimNeg  = -LimPos;
	localparam logic signed [CntW-1:0] HoldLvl = CntW'(adsr_pkg::SUSTAIN_HOLD);
	localparam logic signed [CntW-1:0] CntOne  = CntW'(1);
	localparam int ProdW = adsr_pkg::TimeW + adsr_pkg::SpanW;
	localparam int ExtW  = adsr_pkg::TimeW + 2;

	adsr_pkg::op_t       op;
	adsr_pkg::seq_cond_t cond;

	logic                               skip_q;
	logic signed [CntW-1:0]             deb_q;
	logic                               held_q;
	logic                               tog_q;
	logic [adsr_pkg::PhaseW-1:0]        phase_q;
	logic [adsr_pkg::TimerW-1:0]        timer_q;
	logic                               out_valid_q;
	logic [adsr_pkg::DivCntW-1:0]       dcnt_q;
	logic                               div_q;

	logic [adsr_pkg::GateW-1:0]         gate_q;
	logic [adsr_pkg::TimeW-1:0]         ta_q;
	logic [adsr_pkg::TimeW-1:0]         td_q;
	logic [adsr_pkg::TimeW-1:0]         tr_q;
	logic [adsr_pkg::TimeW-1:0]         divisor_q;
	logic [adsr_pkg::SpanW-1:0]         span_q;
	logic [adsr_pkg::LevelW-1:0]        base_q;
	logic                               sub_q;
	logic [adsr_pkg::TimeW-1:0]         rem_q;
	logic [adsr_pkg::QuoW-1:0]          qr_q;
	logic [adsr_pkg::LevelW-1:0]        level_q;
	logic [adsr_pkg::PhaseW-1:0]        phase_out_q;
	logic                               tog_out_q;

	logic                               accept;
	logic                               cfg_wr;
	logic                               out_free;

	logic signed [CntW-1:0]             deb_up;
	logic signed [CntW-1:0]             deb_dn;
	logic                               retrig;
	logic                               held_up;
	logic                               held_dn;
	logic [adsr_pkg::TimerW-1:0]        timer_inc;

	logic                               ev_hold;
	logic [adsr_pkg::PhaseW-1:0]        ev_phase;
	logic                               ev_div;
	logic [adsr_pkg::TimeW-1:0]         ev_divisor;
	logic [adsr_pkg::SpanW-1:0]         ev_span;
	logic [adsr_pkg::LevelW-1:0]        ev_base;
	logic                               ev_sub;

	logic [ProdW-1:0]                   prod;
	logic [ExtW-1:0]                    div_ext;
	logic [ExtW-1:0]                    div_diff;
	logic                               div_ge;
	logic [adsr_pkg::LevelW-1:0]        quo_ext;
	logic [adsr_pkg::LevelW-1:0]        level_n;

	adsr_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.op     (op)
	);

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[2];
	assign prdata   = paddr[2] ? 32'd0 : {31'd0, skip_q};
	assign in_stall = (op != adsr_pkg::OP_WAIT);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign level          = level_q;
	assign phase          = phase_out_q;
	assign trigger_toggle = tog_out_q;

	always_comb begin
		deb_up = (gate_q > adsr_pkg::GATE_THRESHOLD && deb_q < LimPos) ?
			deb_q + CntOne : deb_q;
		retrig  = (deb_up == LimPos) && !held_q;
		held_up = retrig ? 1'b1 : held_q;
		deb_dn  = (gate_q < adsr_pkg::GATE_THRESHOLD && deb_up > LimNeg) ?
			deb_up - CntOne : deb_up;
		held_dn = (deb_dn == LimNeg) ? 1'b0 : held_up;
		timer_inc = (retrig ? '0 : timer_q) + adsr_pkg::TimerW'(1);
	end

	always_comb begin
		ev_hold    = 1'b1;
		ev_phase   = phase_q;
		ev_div     = 1'b0;
		ev_divisor = ta_q;
		ev_span    = adsr_pkg::ATTACK_SPAN;
		ev_base    = adsr_pkg::LEVEL_ZERO;
		ev_sub     = 1'b0;
		case (phase_q)
			adsr_pkg::PH_ATTACK: begin
				if (timer_q < adsr_pkg::TimerW'(ta_q)) begin
					ev_div = 1'b1;
				end else begin
					ev_hold  = 1'b0;
					ev_phase = adsr_pkg::PH_DECAY;
				end
			end
			adsr_pkg::PH_DECAY: begin
				if (timer_q < adsr_pkg::TimerW'(td_q)) begin
					ev_div     = 1'b1;
					ev_divisor = td_q;
					ev_span    = adsr_pkg::FALL_SPAN;
					ev_base    = adsr_pkg::LEVEL_PEAK;
					ev_sub     = 1'b1;
				end else begin
					ev_hold  = 1'b0;
					ev_phase = skip_q ? adsr_pkg::PH_RELEASE : adsr_pkg::PH_SUSTAIN;
				end
			end
			adsr_pkg::PH_SUSTAIN: begin
				if (deb_q > HoldLvl && held_q) begin
					ev_base = adsr_pkg::LEVEL_SUSTAIN;
				end else begin
					ev_hold  = 1'b0;
					ev_phase = adsr_pkg::PH_RELEASE;
				end
			end
			adsr_pkg::PH_RELEASE: begin
				if (timer_q < adsr_pkg::TimerW'(tr_q)) begin
					ev_div     = 1'b1;
					ev_divisor = tr_q;
					ev_span    = adsr_pkg::FALL_SPAN;
					ev_base    = adsr_pkg::LEVEL_SUSTAIN;
					ev_sub     = 1'b1;
				end else begin
					ev_phase = adsr_pkg::PH_IDLE;
				end
			end
			default: begin
				ev_hold = 1'b1;
			end
		endcase
	end

	// The ramp time is below its length here, so the product shifted down by the
	// quotient width is already a valid partial remainder.
	assign prod = ProdW'(timer_q[adsr_pkg::TimeW-1:0]) * ProdW'(span_q);

	always_comb begin
		div_ext  = {1'b0, rem_q, qr_q[adsr_pkg::QuoW-1]};
		div_diff = div_ext - ExtW'(divisor_q);
		div_ge   = !div_diff[ExtW-1];
		quo_ext  = div_q ? adsr_pkg::LevelW'(qr_q) : '0;
		level_n  = sub_q ? base_q - quo_ext : base_q + quo_ext;
	end

	always_comb begin
		cond.in_valid = in_valid;
		cond.hold     = ev_hold;
		cond.need_div = div_q;
		cond.div_last = (dcnt_q == adsr_pkg::DIV_LAST);
		cond.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q      <= 1'b0;
			deb_q       <= '0;
			held_q      <= 1'b0;
			tog_q       <= 1'b0;
			phase_q     <= adsr_pkg::PH_IDLE;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
			div_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				skip_q <= pwdata[0];
			end
			case (op)
				adsr_pkg::OP_DEB: begin
					deb_q   <= deb_dn;
					held_q  <= held_dn;
					tog_q   <= tog_q ^ retrig;
					timer_q <= timer_inc;
					if (retrig) begin
						phase_q <= adsr_pkg::PH_ATTACK;
					end
				end
				adsr_pkg::OP_EVAL: begin
					phase_q <= ev_phase;
					div_q   <= ev_div;
					if (!ev_hold || phase_q == adsr_pkg::PH_RELEASE &&
							ev_phase == adsr_pkg::PH_IDLE) begin
						timer_q <= '0;
					end
				end
				adsr_pkg::OP_MUL: begin
					dcnt_q <= '0;
				end
				adsr_pkg::OP_DIV: begin
					dcnt_q <= dcnt_q + adsr_pkg::DivCntW'(1);
				end
				default: begin
					dcnt_q <= dcnt_q;
				end
			endcase
			if (op == adsr_pkg::OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gate_q <= gate_sample;
			ta_q   <= attack_time;
			td_q   <= decay_time;
			tr_q   <= release_time;
		end
		if (op == adsr_pkg::OP_EVAL) begin
			divisor_q <= ev_divisor;
			span_q    <= ev_span;
			base_q    <= ev_base;
			sub_q     <= ev_sub;
		end
		if (op == adsr_pkg::OP_MUL) begin
			rem_q <= prod[ProdW-1:adsr_pkg::QuoW];
			qr_q  <= prod[adsr_pkg::QuoW-1:0];
		end
		if (op == adsr_pkg::OP_DIV) begin
			rem_q <= div_ge ? div_diff[adsr_pkg::TimeW-1:0] : div_ext[adsr_pkg::TimeW-1:0];
			qr_q  <= {qr_q[adsr_pkg::QuoW-2:0], div_ge};
		end
		if (op == adsr_pkg::OP_OUT && out_free) begin
			level_q     <= level_n;
			phase_out_q <= phase_q;
			tog_out_q   <= tog_q;
		end
	end

endmodule

### src/adsr_chk.sv
`include "adsr_envelope_generator_top_macros.svh"

module adsr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [adsr_pkg::LevelW-1:0]   level,
	input logic [adsr_pkg::PhaseW-1:0]   phase,
	input logic                          trigger_toggle
);

	logic                                           level_in_range;
	logic                                           idle_item;
	logic                                           sustain_item;
	logic                                           in_accept;
	logic                                           out_held;
	logic [adsr_pkg::LevelW+adsr_pkg::PhaseW:0]     item_bits;

	assign level_in_range = (level >= adsr_pkg::LEVEL_ZERO) && (level <= adsr_pkg::LEVEL_PEAK);
	assign idle_item      = out_valid && (phase == adsr_pkg::PH_IDLE);
	assign sustain_item   = out_valid && (phase == adsr_pkg::PH_SUSTAIN);
	assign in_accept      = in_valid && !in_stall;
	assign out_held       = out_valid && out_stall;
	assign item_bits      = {level, phase, trigger_toggle};

	`ADSR_ASSERT(a_level_range, out_valid |-> level_in_range, "level outside the envelope range")
	`ADSR_ASSERT(a_idle_level, idle_item |-> (level == adsr_pkg::LEVEL_ZERO), "idle item not at zero")
	`ADSR_ASSERT(a_sustain_level, sustain_item |-> (level == adsr_pkg::LEVEL_SUSTAIN), "bad sustain")
	`ADSR_ASSERT(a_busy_after_accept, in_accept |=> in_stall, "input taken during an item")
	`ADSR_ASSERT(a_out_hold, out_held |=> (out_valid && $stable(item_bits)), "stalled item changed")

endmodule

bind adsr_envelope_generator_top adsr_chk u_adsr_chk (.*);

### verif/tb.sv
module tb;

	localparam int DEBOUNCE_LIMIT = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENT_ITEMS = 200;
	localparam int DRAIN_CYCLES = 24;
	localparam logic [2:0] SKIP_SUSTAIN_ADDR = 3'd0;

	typedef struct packed {
		logic [adsr_pkg::GateW-1:0] gate;
		logic [adsr_pkg::TimeW-1:0] ta;
		logic [adsr_pkg::TimeW-1:0] td;
		logic [adsr_pkg::TimeW-1:0] tr;
	} stim_t;

	typedef struct packed {
		logic [adsr_pkg::LevelW-1:0] lvl;
		logic [adsr_pkg::PhaseW-1:0] ph;
		logic                        tog;
	} env_out_t;

	typedef struct packed {
		stim_t    stim;
		logic     known;
		env_out_t typed;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [adsr_pkg::GateW-1:0] gate_sample = '0;
	logic [adsr_pkg::TimeW-1:0] attack_time = '0;
	logic [adsr_pkg::TimeW-1:0] decay_time = '0;
	logic [adsr_pkg::TimeW-1:0] release_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [adsr_pkg::LevelW-1:0] level;
	logic [adsr_pkg::PhaseW-1:0] phase;
	logic trigger_toggle;

	adsr_envelope_generator_top #(.DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.gate_sample(gate_sample), .attack_time(attack_time),
		.decay_time(decay_time), .release_time(release_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.level(level), .phase(phase), .trigger_toggle(trigger_toggle)
	);

	// Predictor state.
	int                          debounce;
	logic                        held;
	logic                        toggle;
	logic [adsr_pkg::PhaseW-1:0] env_phase;
	logic [adsr_pkg::TimerW-1:0] timer;
	logic                        skip_cfg;

	env_out_t pending_env [$];
	int  mismatches;
	int  results_checked;
	int  items_sent;
	int  retriggers;
	logic [7:0] phases_seen;
	bit  calm;

	dir_row_t dir_rows [0:19] = '{
		'{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{adsr_pkg::GATE_THRESHOLD, 12'd4095, 12'd4095, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd2529, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd2529, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd2529, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd2529, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b0}},
		'{'{12'd4095, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_SUSTAIN, 1'b1}},
		'{'{12'd2529, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_SUSTAIN, 1'b1}},
		'{'{12'd2527, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_SUSTAIN, 1'b1}},
		'{'{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_SUSTAIN, 1'b1}},
		'{'{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_SUSTAIN, 1'b1}},
		'{'{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_SUSTAIN, adsr_pkg::PH_RELEASE, 1'b1}},
		'{'{12'd0, 12'd0, 12'd0, 12'd2}, 1'b0, '0},
		'{'{12'd0, 12'd0, 12'd0, 12'd2}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b1}},
		'{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b1}},
		'{'{12'd0, 12'd4095, 12'd4095, 12'd4095}, 1'b1,
			'{adsr_pkg::LEVEL_ZERO, adsr_pkg::PH_IDLE, 1'b1}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic env_out_t advance_envelope(input stim_t s);
		env_out_t r;
		int unsigned lv;
		lv = adsr_pkg::LEVEL_ZERO;
		if (s.gate > adsr_pkg::GATE_THRESHOLD && debounce < DEBOUNCE_LIMIT)
			debounce++;
		if (debounce == DEBOUNCE_LIMIT && !held) begin
			env_phase = adsr_pkg::PH_ATTACK;
			timer = '0;
			held = 1'b1;
			toggle = ~toggle;
			retriggers++;
		end
		if (s.gate < adsr_pkg::GATE_THRESHOLD && debounce > -DEBOUNCE_LIMIT)
			debounce--;
		if (debounce == -DEBOUNCE_LIMIT && held)
			held = 1'b0;
		timer = timer + 1'b1;
		if (env_phase == adsr_pkg::PH_ATTACK) begin
			if (timer < s.ta)
				lv = 32'(timer) * 32'(adsr_pkg::ATTACK_SPAN) / 32'(s.ta)
					+ 32'(adsr_pkg::LEVEL_ZERO);
			else begin
				env_phase = adsr_pkg::PH_DECAY;
				timer = '0;
			end
		end
		if (env_phase == adsr_pkg::PH_DECAY) begin
			if (timer < s.td)
				lv = 32'(adsr_pkg::LEVEL_PEAK)
					- 32'(timer) * 32'(adsr_pkg::FALL_SPAN) / 32'(s.td);
			else begin
				env_phase = skip_cfg ? adsr_pkg::PH_RELEASE : adsr_pkg::PH_SUSTAIN;
				timer = '0;
			end
		end
		if (env_phase == adsr_pkg::PH_SUSTAIN) begin
			if (debounce > adsr_pkg::SUSTAIN_HOLD && held)
				lv = adsr_pkg::LEVEL_SUSTAIN;
			else begin
				env_phase = adsr_pkg::PH_RELEASE;
				timer = '0;
			end
		end
		if (env_phase == adsr_pkg::PH_RELEASE) begin
			if (timer < s.tr)
				lv = 32'(adsr_pkg::LEVEL_SUSTAIN)
					- 32'(timer) * 32'(adsr_pkg::FALL_SPAN) / 32'(s.tr);
			else begin
				env_phase = adsr_pkg::PH_IDLE;
				timer = '0;
				lv = adsr_pkg::LEVEL_ZERO;
			end
		end
		phases_seen[env_phase] = 1'b1;
		r.lvl = lv[adsr_pkg::LevelW-1:0];
		r.ph = env_phase;
		r.tog = toggle;
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	task automatic send_item(input stim_t s, input logic known, input env_out_t typed);
		env_out_t pred;
		calm = (items_sent >= 350 && items_sent < 500);
		while (!calm && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		gate_sample <= s.gate;
		attack_time <= s.ta;
		decay_time <= s.td;
		release_time <= s.tr;
		do
			@(posedge clk);
		while (in_stall);
		pred = advance_envelope(s);
		pending_env.push_back(known ? typed : pred);
		items_sent++;
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_env.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_skip_sustain(input logic value);
		logic [31:0] rd;
		apb_access(1'b1, SKIP_SUSTAIN_ADDR, 32'(value), rd);
		skip_cfg = value;
		apb_access(1'b0, SKIP_SUSTAIN_ADDR, '0, rd);
		if (rd !== 32'(value))
			note_mismatch($sformatf("skip_sustain readback expected %0d got %0h", value, rd));
	endtask

	function automatic logic [adsr_pkg::TimeW-1:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 75)
			return adsr_pkg::TimeW'($urandom_range(1, 40));
		if (r < 92)
			return adsr_pkg::TimeW'($urandom_range(41, 300));
		return adsr_pkg::TimeW'($urandom_range(0, 4095));
	endfunction

	task automatic play_note();
		stim_t s;
		int hi_len;
		int lo_len;
		bit jitter;
		s.ta = pick_time();
		s.td = pick_time();
		s.tr = pick_time();
		jitter = ($urandom_range(0, 7) == 0);
		hi_len = $urandom_range(1, 50);
		lo_len = $urandom_range(1, 60);
		repeat (hi_len) begin
			if (jitter) begin
				s.ta = pick_time();
				s.td = pick_time();
				s.tr = pick_time();
			end
			s.gate = ($urandom_range(0, 19) == 0) ? adsr_pkg::GATE_THRESHOLD
				: adsr_pkg::GateW'($urandom_range(2529, 4095));
			send_item(s, 1'b0, '0);
		end
		repeat (lo_len) begin
			s.gate = ($urandom_range(0, 19) == 0) ? adsr_pkg::GATE_THRESHOLD
				: adsr_pkg::GateW'($urandom_range(0, 2527));
			send_item(s, 1'b0, '0);
		end
	endtask

	task automatic play_noise();
		stim_t s;
		repeat ($urandom_range(1, 20)) begin
			s.gate = adsr_pkg::GateW'($urandom_range(0, 4095));
			s.ta = adsr_pkg::TimeW'($urandom_range(0, 4095));
			s.td = adsr_pkg::TimeW'($urandom_range(0, 4095));
			s.tr = adsr_pkg::TimeW'($urandom_range(0, 4095));
			send_item(s, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : result_check
		env_out_t got;
		env_out_t want;
		out_stall <= !calm && ($urandom_range(0, 99) < 36);
		if (arst_n && out_valid && !out_stall) begin
			got = '{level, phase, trigger_toggle};
			results_checked++;
			if (pending_env.size() == 0)
				note_mismatch($sformatf("unexpected item level %0d phase %0d toggle %0d",
					got.lvl, got.ph, got.tog));
			else begin
				want = pending_env.pop_front();
				if (got !== want)
					note_mismatch($sformatf(
						"item %0d expected level %0d phase %0d toggle %0d, got %0d %0d %0d",
						results_checked, want.lvl, want.ph, want.tog,
						got.lvl, got.ph, got.tog));
			end
		end
	end

	initial begin : timeout_watch
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		debounce = 0;
		held = 1'b0;
		toggle = 1'b0;
		env_phase = adsr_pkg::PH_IDLE;
		timer = '0;
		skip_cfg = 1'b0;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		retriggers = 0;
		phases_seen = '0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].typed);
		for (int seg = 0; seg < 4; seg++) begin
			drain_block();
			set_skip_sustain((seg % 2) == 0);
			while (items_sent < $size(dir_rows) + SEGMENT_ITEMS * (seg + 1)) begin
				if ($urandom_range(0, 99) < 85)
					play_note();
				else
					play_noise();
			end
		end
		drain_block();
		$display("covered %0d items and %0d results, %0d confirmed retriggers",
			items_sent, results_checked, retriggers);
		$display("phases reached %b, skip_sustain run at both values", phases_seen[4:0]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### adsr_envelope_generator_top.f
+incdir+src
src/adsr_pkg.sv
src/adsr_useq.sv
src/adsr_envelope_generator_top.sv
src/adsr_chk.sv
verif/tb.sv
